### hdl/dqhr_pkg.sv
// ----------------------------------------------------------------------------
// dqhr_pkg
// Shared widths, command codes and result status codes for the deque with
// half rotation.
// ----------------------------------------------------------------------------
package dqhr_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_SWAP       = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_POPPED = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

endpackage

### hdl/dqhr_store.sv
// ----------------------------------------------------------------------------
// dqhr_store
// Element store: one write port, one read port, registered read data.
// A read and a write to the same entry in one cycle return the old
// contents.
// ----------------------------------------------------------------------------
module dqhr_store #(
  parameter int DEPTH = dqhr_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [dqhr_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [dqhr_pkg::DATA_W-1:0] rdata
);
  import dqhr_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/deque_with_half_rotation.sv
// ----------------------------------------------------------------------------
// deque_with_half_rotation
// Bounded double-ended queue of signed 32-bit values held in a circular
// store, with push/pop at both ends and a half swap.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken on a rising edge with start high and
//   busy low (in_func, in_value). Every command gives exactly one result:
//   out_valid is high for one cycle with out_status and out_popped. The
//   receiver cannot stall; results are never held back.
// Timing:
//   Push, pop on empty, swap on fewer than two entries, swap on a full
//   queue and unused codes: busy stays low and the result appears in the
//   cycle after accept, so such commands can follow every cycle.
//   Pop: the store read data is registered; busy is high during ST_POP and
//   the result register is loaded from the read data in ST_POP.
//   Swap of count entries (2 <= count < DEPTH): the front half,
//   floor(count/2) entries, is copied behind the back through the store's
//   single read port, one entry per cycle, with busy high throughout; the
//   result follows the last write.
// Reset:
//   rst_n low empties the queue (count and front pointer cleared). The
//   store itself is not cleared; only held entries are ever read.
// ----------------------------------------------------------------------------
module deque_with_half_rotation #(
  parameter int DEPTH = dqhr_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [dqhr_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [dqhr_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  output logic [dqhr_pkg::STAT_W-1:0]        out_status,
  output logic signed [dqhr_pkg::DATA_W-1:0] out_popped
);
  import dqhr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_ROT  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [AW-1:0]     dst_r, dst_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_popped_r, out_popped_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [CW-1:0]     half;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     back_pos;
  logic [AW-1:0]     tail_pos;

  // (a + b) mod DEPTH for a < DEPTH, b <= DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign accept    = start && (state_r == ST_IDLE);
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign half      = count_r >> 1;
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign tail_pos  = wrap_add(front_r, count_r);
  assign back_pos  = wrap_add(front_r, count_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    left_nxt       = left_r;
    wr_pend_nxt    = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_popped_nxt = out_popped_r;
    mem_we         = 1'b0;
    mem_waddr      = tail_pos;
    mem_wdata      = in_value;
    mem_re         = 1'b0;
    mem_raddr      = front_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_status_nxt = STAT_DONE;
          out_popped_nxt = '0;
          unique case (in_func) inside
            FN_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            FN_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_pos;
                count_nxt = count_r + 1'b1;
              end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                count_nxt = count_r - 1'b1;
                state_nxt = ST_POP;
                if (in_func == FN_POP_FRONT) begin
                  mem_raddr = front_r;
                  front_nxt = wrap_add(front_r, CW'(1));
                end else begin
                  mem_raddr = back_pos;
                end
              end
            end
            FN_SWAP: begin
              if (count_r < CW'(2)) begin
                out_valid_nxt = 1'b1;
              end else if (is_full) begin
                // no gap in the ring: rotation is a pointer move
                out_valid_nxt = 1'b1;
                front_nxt     = wrap_add(front_r, half);
              end else begin
                // move the first half behind the back, then advance front
                src_nxt   = front_r;
                dst_nxt   = tail_pos;
                left_nxt  = half;
                front_nxt = wrap_add(front_r, half);
                state_nxt = ST_ROT;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_POPPED;
        out_popped_nxt = mem_rdata;
        state_nxt      = ST_IDLE;
      end
      ST_ROT: begin
        mem_we    = wr_pend_r;
        mem_waddr = dst_r;
        mem_wdata = mem_rdata;
        if (wr_pend_r) begin
          dst_nxt = wrap_add(dst_r, CW'(1));
        end
        if (left_r != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = src_r;
          src_nxt     = wrap_add(src_r, CW'(1));
          left_nxt    = left_r - 1'b1;
          wr_pend_nxt = 1'b1;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DONE;
          out_popped_nxt = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    left_r       <= left_nxt;
    out_status_r <= out_status_nxt;
    out_popped_r <= out_popped_nxt;
  end

  dqhr_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_popped = out_popped_r;

  // occupancy never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("deque count above capacity");

  // popped data is zero unless a value was popped
  a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != STAT_POPPED) |-> (out_popped_r == '0))
    else $error("nonzero popped data without a pop");

  // copy loop: once all reads are issued, the last write is still pending
  a_rot_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT) && (left_r == '0) |-> wr_pend_r)
    else $error("swap finished without final write");

  // a transaction accepted while idle gets its result or enters a busy state
  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || busy))
    else $error("accepted transaction produced no response");

  // a pop with data reports its result in the cycle after ST_POP
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |=> out_valid_r && (out_status_r == STAT_POPPED))
    else $error("pop result missing");

endmodule

### tb/sv/dqhr_deque_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqhr_deque_check
// Watches command and result transactions of the deque, keeps a shadow copy
// of the held sequence and compares every result against the expected one.
// ----------------------------------------------------------------------------
module dqhr_deque_check #(
  parameter int DEPTH = dqhr_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [dqhr_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [dqhr_pkg::DATA_W-1:0] in_value,
  input  logic                               out_valid,
  input  logic [dqhr_pkg::STAT_W-1:0]        out_status,
  input  logic signed [dqhr_pkg::DATA_W-1:0] out_popped,
  output int                                 errors,
  output int                                 pending
);
  import dqhr_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] popped;
  } deque_result_t;

  logic signed [DATA_W-1:0] held_q[$];   // front of the deque at index 0
  deque_result_t            due_q[$];
  deque_result_t            want;

  function automatic deque_result_t deque_apply(logic [FUNC_W-1:0] fn,
                                                logic signed [DATA_W-1:0] val);
    deque_result_t r;
    int half;
    r.status = STAT_DONE;
    r.popped = '0;
    case (fn) inside
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (held_q.size() >= DEPTH) r.status = STAT_FULL;
        else if (fn == FN_PUSH_FRONT) held_q.push_front(val);
        else held_q.push_back(val);
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (held_q.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.status = STAT_POPPED;
          if (fn == FN_POP_FRONT) r.popped = held_q.pop_front();
          else r.popped = held_q.pop_back();
        end
      end
      FN_SWAP: begin
        // rotate left by floor(count/2); no-op below two entries
        half = held_q.size() / 2;
        repeat (half) held_q.push_back(held_q.pop_front());
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $time, msg);
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      held_q.delete();
      due_q.delete();
      pending = 0;
    end else begin
      // a result never belongs to a command taken on the same edge
      if (out_valid === 1'b1) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("result with no command pending: status %0d popped %0d",
                                    out_status, out_popped));
        end else begin
          want = due_q.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status mismatch: expected %0d, got %0d",
                                      want.status, out_status));
          if (out_popped !== want.popped)
            report_mismatch($sformatf("popped mismatch: expected %0d, got %0d",
                                      want.popped, out_popped));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        due_q.push_back(deque_apply(in_func, in_value));
      pending = due_q.size();
    end
  end

endmodule

### tb/sv/tb_deque_with_half_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_with_half_rotation
// Drives command transactions into the deque: a directed opening over empty,
// single-entry and odd/even swaps, then random phases that mix, fill to full,
// sit at full and drain. Checking is done by dqhr_deque_check.
// ----------------------------------------------------------------------------
module tb_deque_with_half_rotation;
  import dqhr_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int FN_SPARE_LO = int'(FN_SWAP) + 1;
  localparam int FN_SPARE_HI = (1 << FUNC_W) - 1;
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [FUNC_W-1:0]        in_func;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_popped;

  int errors;
  int pending;
  int level;     // held entries, only used to steer the command mix
  int sent;
  int waited;
  bit no_idle;

  deque_with_half_rotation #(.DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_popped (out_popped)
  );

  dqhr_deque_check #(.DEPTH(DEPTH)) i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_popped (out_popped),
    .errors     (errors),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 70) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // one command transaction; start stays high across back-to-back commands
  task automatic issue(logic [FUNC_W-1:0] fn, logic signed [DATA_W-1:0] val);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    start    <= 1'b1;
    in_func  <= fn;
    in_value <= val;
    do @(posedge clk); while (busy);
    case (fn) inside
      FN_PUSH_FRONT, FN_PUSH_BACK: if (level < DEPTH) level++;
      FN_POP_FRONT, FN_POP_BACK:   if (level > 0) level--;
      default: ;
    endcase
    sent++;
    if (sent % 64 == 0) no_idle = ($urandom_range(3) == 0);
    if (gap > 0) begin
      @(negedge clk);
      start    <= 1'b0;
      in_func  <= FUNC_W'($urandom);
      in_value <= DATA_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // weights in percent; the rest goes to the unused codes
  task automatic random_cmd(int w_push, int w_pop, int w_swap);
    int r;
    logic [FUNC_W-1:0] fn;
    r = $urandom_range(99);
    if (r < w_push) fn = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
    else if (r < w_push + w_pop) fn = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
    else if (r < w_push + w_pop + w_swap) fn = FN_SWAP;
    else fn = FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
    issue(fn, pick_value());
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_func  = '0;
    in_value = '0;
    level    = 0;
    sent     = 0;
    no_idle  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty queue
    issue(FN_POP_FRONT, pick_value());
    issue(FN_POP_BACK, pick_value());
    issue(FN_SWAP, pick_value());
    // single entry, swap is a no-op
    issue(FN_PUSH_BACK, VAL_MAX);
    issue(FN_SWAP, '0);
    issue(FN_POP_FRONT, '0);
    issue(FN_PUSH_FRONT, VAL_MIN);
    issue(FN_POP_BACK, '0);
    // odd and even swaps
    issue(FN_PUSH_BACK, '0);
    issue(FN_PUSH_BACK, '1);
    issue(FN_PUSH_FRONT, 32'sd1);
    issue(FN_PUSH_BACK, 32'h5555_5555);
    issue(FN_PUSH_FRONT, 32'haaaa_aaaa);
    issue(FN_SWAP, '0);
    issue(FN_PUSH_BACK, 32'sd2);
    issue(FN_SWAP, '0);
    issue(FN_POP_FRONT, '0);
    issue(FN_POP_BACK, '0);
    issue(3'(FN_SPARE_LO), VAL_MAX);
    issue(3'(FN_SPARE_LO + 1), VAL_MIN);
    issue(3'(FN_SPARE_HI), '1);

    repeat (200) random_cmd(45, 35, 15);
    while (level < DEPTH) random_cmd(93, 3, 4);
    repeat (40) random_cmd(60, 25, 10);
    repeat (100) random_cmd(15, 70, 10);

    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 8 * DEPTH) begin
      @(negedge clk);
      waited++;
    end
    if (pending != 0) begin
      $display("DONE: errors detected");
    end else begin
      repeat (16) @(negedge clk);
      if (errors == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
    end
    $finish;
  end

endmodule
